// ===== hw/rtl/streaming_matrix_multiply_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the streaming matrix multiplier
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef STREAMING_MATRIX_MULTIPLY_DEFINES_SVH
`define STREAMING_MATRIX_MULTIPLY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SMM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("smm check failed");
`define SMM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
  else $error("smm forbidden condition seen");
`else
`define SMM_ASSERT(lbl, clk, rst_n, prop)
`define SMM_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/smm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming matrix multiplier package
// Sizes, beat and control types, and sequencer states shared by the design and testbench modules.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int DIM    = 8;
  localparam int CELLS  = DIM * DIM;
  localparam int DATA_W = 32;
  localparam int K_W    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W = $clog2(CELLS);

  typedef logic [DATA_W-1:0]        word_t;
  typedef logic signed [DATA_W-1:0] sword_t;
  typedef logic [K_W-1:0]           kidx_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  localparam kidx_t K_LAST = kidx_t'(DIM - 1);
  localparam addr_t A_LAST = addr_t'(CELLS - 1);

  typedef struct packed {
    logic  vld;
    kidx_t k;
    word_t data;
  } a_beat_t;

  typedef struct packed {
    logic  b_shift;
    logic  b_commit;
    kidx_t b_row;
    logic  res_load;
    logic  res_shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_FEED,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

endpackage

// ===== hw/rtl/smm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming matrix multiplier channels
// Valid/ready channels for input elements and product elements.
// ----------------------------------------------------------------------------
interface smm_in_if;
  import smm_pkg::*;

  logic   valid;
  logic   ready;
  sword_t element;

  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface smm_out_if;
  import smm_pkg::*;

  logic   valid;
  logic   ready;
  sword_t product_element;
  logic   final_flag;

  modport source (output valid, output product_element, output final_flag, input ready);
  modport sink (input valid, input product_element, input final_flag, output ready);
endinterface

// ===== hw/rtl/smm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate cell
// Holds one column of the right matrix and accumulates one product entry.
// ----------------------------------------------------------------------------
module smm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  smm_pkg::cell_ctrl_t ctrl,
  input  smm_pkg::a_beat_t   a_in,
  output smm_pkg::a_beat_t   a_out,
  input  smm_pkg::word_t     b_in,
  output smm_pkg::word_t     b_out,
  input  smm_pkg::word_t     res_in,
  output smm_pkg::word_t     res_out,
  output logic               done
);
  import smm_pkg::*;

  logic  a_vld_r;
  kidx_t a_k_r;
  word_t a_data_r;
  word_t b_hold_r;
  word_t b_col_r [DIM];
  word_t prod_r;
  word_t prod_nxt;
  logic  prod_vld_r;
  logic  prod_first_r;
  logic  prod_last_r;
  word_t acc_r;
  word_t acc_nxt;
  word_t res_r;
  logic  done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      prod_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      a_vld_r    <= a_in.vld;
      prod_vld_r <= a_vld_r;
      done_r     <= prod_vld_r && prod_last_r;
    end
  end

  always_comb begin
    prod_nxt = a_data_r * b_col_r[a_k_r];
    acc_nxt  = prod_first_r ? prod_r : acc_r + prod_r;
  end

  always_ff @(posedge clk) begin
    a_k_r        <= a_in.k;
    a_data_r     <= a_in.data;
    prod_r       <= prod_nxt;
    prod_first_r <= (a_k_r == '0);
    prod_last_r  <= (a_k_r == K_LAST);
    if (ctrl.b_shift) begin
      b_hold_r <= b_in;
    end
    if (ctrl.b_commit) begin
      b_col_r[ctrl.b_row] <= b_hold_r;
    end
    if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.res_load) begin
      res_r <= acc_r;
    end else if (ctrl.res_shift) begin
      res_r <= res_in;
    end
  end

  assign a_out   = '{vld: a_vld_r, k: a_k_r, data: a_data_r};
  assign b_out   = b_hold_r;
  assign res_out = res_r;
  assign done    = done_r;

endmodule

// ===== hw/rtl/smm_seq.sv =====
`timescale 1ns / 1ps
`include "streaming_matrix_multiply_defines.svh"
// ----------------------------------------------------------------------------
// Matrix multiplier sequencer
// Loads both matrices, stores the left one, and runs the cell chain row by row.
// ----------------------------------------------------------------------------
module smm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smm_pkg::word_t      in_element,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_final,
  input  logic                done,
  output smm_pkg::cell_ctrl_t ctrl,
  output smm_pkg::word_t      b_data,
  output smm_pkg::a_beat_t    a_beat
);
  import smm_pkg::*;

  seq_state_t state_r;
  seq_state_t state_nxt;

  word_t a_mem [CELLS];
  word_t a_rd_data_r;
  logic  rd_vld_r;
  kidx_t rd_k_r;
  addr_t rd_addr_r;
  logic  rd_en;

  logic  ld_phase_r;
  addr_t ld_addr_r;
  kidx_t ld_col_r;
  kidx_t ld_row_r;
  logic  commit_r;
  kidx_t commit_row_r;

  kidx_t feed_k_r;
  kidx_t row_r;
  kidx_t emit_k_r;

  logic accept;
  logic b_last_col;
  logic load_done;
  logic emit_beat;

  assign accept     = in_valid && in_ready;
  assign b_last_col = ld_phase_r && (ld_col_r == K_LAST);
  assign load_done  = accept && b_last_col && (ld_row_r == K_LAST);
  assign emit_beat  = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (load_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_FEED;
      end
      ST_FEED: begin
        if (feed_k_r == K_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_beat && (emit_k_r == K_LAST)) begin
          state_nxt = (row_r == K_LAST) ? ST_LOAD : ST_FEED;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_LOAD);
    out_valid      = (state_r == ST_EMIT);
    out_final      = out_valid && (row_r == K_LAST) && (emit_k_r == K_LAST);
    rd_en          = (state_r == ST_FEED);
    ctrl.b_shift   = accept && ld_phase_r;
    ctrl.b_commit  = commit_r;
    ctrl.b_row     = commit_row_r;
    ctrl.res_load  = (state_r == ST_DRAIN) && done;
    ctrl.res_shift = emit_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      ld_phase_r <= 1'b0;
      ld_addr_r  <= '0;
      ld_col_r   <= '0;
      ld_row_r   <= '0;
      commit_r   <= 1'b0;
      rd_vld_r   <= 1'b0;
      rd_addr_r  <= '0;
      feed_k_r   <= '0;
      row_r      <= '0;
      emit_k_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      commit_r <= accept && b_last_col;
      rd_vld_r <= rd_en;
      if (accept) begin
        if (!ld_phase_r) begin
          ld_addr_r <= (ld_addr_r == A_LAST) ? '0 : ld_addr_r + 1'b1;
          if (ld_addr_r == A_LAST) begin
            ld_phase_r <= 1'b1;
          end
        end else if (ld_col_r == K_LAST) begin
          ld_col_r <= '0;
          if (ld_row_r == K_LAST) begin
            ld_row_r   <= '0;
            ld_phase_r <= 1'b0;
          end else begin
            ld_row_r <= ld_row_r + 1'b1;
          end
        end else begin
          ld_col_r <= ld_col_r + 1'b1;
        end
      end
      if (rd_en) begin
        rd_addr_r <= (rd_addr_r == A_LAST) ? '0 : rd_addr_r + 1'b1;
        feed_k_r  <= (feed_k_r == K_LAST) ? '0 : feed_k_r + 1'b1;
      end
      if (emit_beat) begin
        if (emit_k_r == K_LAST) begin
          emit_k_r <= '0;
          row_r    <= (row_r == K_LAST) ? '0 : row_r + 1'b1;
        end else begin
          emit_k_r <= emit_k_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    commit_row_r <= ld_row_r;
    rd_k_r       <= feed_k_r;
    if (accept && !ld_phase_r) begin
      a_mem[ld_addr_r] <= in_element;
    end
    if (rd_en) begin
      a_rd_data_r <= a_mem[rd_addr_r];
    end
  end

  assign b_data = in_element;
  assign a_beat = '{vld: rd_vld_r, k: rd_k_r, data: a_rd_data_r};

  `SMM_NEVER(a_emit_no_accept, clk, rst_n, out_valid && in_ready)
  `SMM_ASSERT(a_flush_commits, clk, rst_n, (state_r == ST_FLUSH) |-> commit_r)
  `SMM_ASSERT(a_done_in_drain, clk, rst_n, done |-> (state_r == ST_DRAIN))
  `SMM_ASSERT(a_final_to_load, clk, rst_n, (emit_beat && out_final) |=> (state_r == ST_LOAD))

endmodule

// ===== hw/rtl/streaming_matrix_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming matrix multiplier
// Multiplies two square signed 32-bit matrices streamed in row-major order.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload                           Beat
// in_if    sink       element                           one left, then right element
// out_if   source     product_element, final_flag       one product entry
//
// A pair of matrices goes through these steps: every input beat is accepted, a
// flush state follows, then for each product row the left row is fed into the
// chain of DIM multiply-accumulate cells, and the row leaves as DIM output beats.
// Input is accepted only while matrices load; reset is synchronous, active low.
// A stalled output holds the chain; no input is taken until the last beat leaves.
// ----------------------------------------------------------------------------
module streaming_matrix_multiply (
  input  logic      clk,
  input  logic      rst_n,
  smm_in_if.sink    in_if,
  smm_out_if.source out_if
);
  import smm_pkg::*;

  cell_ctrl_t ctrl;
  a_beat_t    a_link [DIM];
  word_t      b_link [DIM];
  word_t      res_link [DIM];
  word_t      in_word;
  logic       last_done;

  assign in_word = word_t'(in_if.element);

  smm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_element (in_word),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_final  (out_if.final_flag),
    .done       (last_done),
    .ctrl       (ctrl),
    .b_data     (b_link[DIM-1]),
    .a_beat     (a_link[0])
  );

  for (genvar g = 0; g < DIM; g++) begin : g_cell
    if (g == DIM - 1) begin : g_last
      smm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .a_in    (a_link[g]),
        .a_out   (),
        .b_in    (b_link[g]),
        .b_out   (b_link[g-1]),
        .res_in  ('0),
        .res_out (res_link[g]),
        .done    (last_done)
      );
    end else if (g == 0) begin : g_first
      smm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .a_in    (a_link[g]),
        .a_out   (a_link[g+1]),
        .b_in    (b_link[g]),
        .b_out   (),
        .res_in  (res_link[g+1]),
        .res_out (res_link[g]),
        .done    ()
      );
    end else begin : g_mid
      smm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .a_in    (a_link[g]),
        .a_out   (a_link[g+1]),
        .b_in    (b_link[g]),
        .b_out   (b_link[g-1]),
        .res_in  (res_link[g+1]),
        .res_out (res_link[g]),
        .done    ()
      );
    end
  end

  assign out_if.product_element = sword_t'(res_link[0]);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming matrix multiplier testbench
// Streams pairs of 8x8 signed matrices into the block under bursty input and
// stalling output, predicts each product matrix with wrapping 32-bit sums, and
// compares every product beat and its last flag in order against the forecast.
// ----------------------------------------------------------------------------
module tb;
  import smm_pkg::*;

  localparam int TARGET_ELEMENTS = 420;
  localparam int SETTLE_CYCLES   = 1000;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct {
    word_t value;
    logic  last;
  } product_t;

  typedef enum {
    FILL_FULL,
    FILL_SMALL,
    FILL_EXTREME,
    FILL_SPARSE
  } fill_t;

  class product_scoreboard;
    word_t       left_cells[CELLS];
    word_t       right_cells[CELLS];
    int unsigned loaded;
    product_t    pending[$];
    int          failures;

    function new();
      loaded   = 0;
      failures = 0;
    endfunction

    function void take_element(word_t v);
      word_t    acc;
      product_t p;
      if (loaded < CELLS) begin
        left_cells[loaded] = v;
      end else begin
        right_cells[loaded - CELLS] = v;
      end
      loaded++;
      if (loaded == 2 * CELLS) begin
        loaded = 0;
        for (int r = 0; r < DIM; r++) begin
          for (int c = 0; c < DIM; c++) begin
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
              acc = acc + left_cells[r * DIM + k] * right_cells[k * DIM + c];
            end
            p.value = acc;
            p.last  = (r == DIM - 1) && (c == DIM - 1);
            pending.push_back(p);
          end
        end
      end
    endfunction

    function void check_product(word_t v, logic last);
      product_t p;
      if (pending.size() == 0) begin
        failures++;
        $display("%0t: unexpected product beat: actual value %0d last %0b",
                 $time, $signed(v), last);
      end else begin
        p = pending.pop_front();
        if (v !== p.value) begin
          failures++;
          $display("%0t: product_element mismatch: expected %0d (%h) actual %0d (%h)",
                   $time, $signed(p.value), p.value, $signed(v), v);
        end
        if (last !== p.last) begin
          failures++;
          $display("%0t: final_flag mismatch: expected %0b actual %0b",
                   $time, p.last, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  smm_in_if  in_ch ();
  smm_out_if out_ch ();

  streaming_matrix_multiply dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  product_scoreboard sb = new();

  int unsigned sent_elements = 0;
  int unsigned burst_left    = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t extreme_value(int unsigned i);
    case (i % 8)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      5:       return 32'h5555_5555;
      6:       return 32'hAAAA_AAAA;
      default: return 32'h8000_0001;
    endcase
  endfunction

  function automatic word_t draw_element(fill_t fill);
    case (fill)
      FILL_SMALL:   return word_t'($urandom_range(0, 16)) - word_t'(8);
      FILL_EXTREME: return ($urandom_range(0, 3) == 0) ? word_t'($urandom())
                                                       : extreme_value($urandom());
      FILL_SPARSE:  return ($urandom_range(0, 4) == 0) ? word_t'($urandom()) : '0;
      default:      return word_t'($urandom());
    endcase
  endfunction

  // The valid line is only lowered when a gap begins, so back-to-back beats
  // never see it dropped and raised in one step.
  task automatic send_element(input word_t v, input bit paced);
    if (paced && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid   <= 1'b1;
    in_ch.element <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_element(v);
    sent_elements++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_random_pair();
    fill_t fill;
    bit    paced;
    paced = $urandom_range(0, 3) != 0;
    for (int i = 0; i < 2 * CELLS; i++) begin
      if (i % CELLS == 0) fill = fill_t'($urandom_range(0, 3));
      send_element(draw_element(fill), paced);
    end
  endtask

  initial begin
    int mode;
    int hold;
    out_ch.ready <= 1'b0;
    mode = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(30, 200);
      end
      hold--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (hold % 5) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_product(out_ch.product_element, out_ch.final_flag);
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL streaming_matrix_multiply");
    $finish;
  end

  initial begin
    int unsigned row;
    word_t       v;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.element <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-scale rows force products and sums to wrap around.
    for (int i = 0; i < 2 * CELLS; i++) begin
      row = (i % CELLS) / DIM;
      if (row == 0) begin
        v = 32'h7FFF_FFFF;
      end else if (row == 1) begin
        v = 32'h8000_0000;
      end else begin
        v = extreme_value(i + i / DIM);
      end
      send_element(v, 1'b0);
    end

    while (sent_elements + CELLS <= TARGET_ELEMENTS) send_random_pair();
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.failures == 0) begin
      $display("PASS streaming_matrix_multiply");
    end else begin
      $display("FAIL streaming_matrix_multiply");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/smm_pkg.sv
hw/rtl/smm_if.sv
hw/rtl/smm_cell.sv
hw/rtl/smm_seq.sv
hw/rtl/streaming_matrix_multiply.sv
tb/sv/tb.sv
